// ===== hdl/twq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package twq_pkg;

	localparam int QUEUE_DEPTH   = 16;
	localparam int PAYLOAD_WIDTH = 32;
	localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
	localparam int BURST_W       = 4;

	localparam logic [BURST_W-1:0] BURST_RESET = BURST_W'(2);
	localparam logic [BURST_W-1:0] BURST_MAX   = '1;

	// operation codes carried on the input word
	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_DEQUEUE = 1'b1;

	localparam int OUT_BITS = 2 * (2 + PAYLOAD_WIDTH) + 1 + 2 * CNT_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [1:0] {
		SRC_NONE,
		SRC_PRIO_CNT,
		SRC_NORM,
		SRC_PRIO_HOLD
	} src_t;

	typedef struct packed {
		logic enq;
		logic deq;
	} q_ctrl_t;

	typedef struct packed {
		logic [CNT_W-1:0]         count;
		logic                     full;
		logic [PAYLOAD_WIDTH-1:0] head;
	} q_stat_t;

	// weighted pick: priority while burst below limit, else normal, else priority
	function automatic src_t choose_src(
		input logic [CNT_W-1:0]   p_count,
		input logic [CNT_W-1:0]   n_count,
		input logic [BURST_W-1:0] burst,
		input logic [BURST_W-1:0] limit
	);
		src_t s;
		if (p_count != '0 && burst < limit) s = SRC_PRIO_CNT;
		else if (n_count != '0)             s = SRC_NORM;
		else if (p_count != '0)             s = SRC_PRIO_HOLD;
		else                                s = SRC_NONE;
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/two_class_weighted_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two-class weighted queue. Words enter on s_* (tuser[0] operation: 0 enqueue,
// 1 dequeue; tuser[1] class, 1 = priority; tdata the payload). Each queue is a
// row of sixteen cells with its head in the first cell; a dequeue shifts the
// whole row one cell towards the head, an enqueue writes the cell at the fill
// count. Priority is served while the burst counter is below priority_burst
// (cfg port, reset 2), then one normal entry, which clears the counter; with
// the burst used up and no normal entry, priority is served and the counter
// holds. Each input word yields one output word: at acceptance the cell rows
// are updated, then the new heads are read into the output register. A new
// word is not taken while the last one is pending, and only once the output
// register is free or being drained. Enqueues to a full queue are dropped and
// flagged. Write priority_burst only while idle.

module two_class_weighted_queue
	import twq_pkg::*;
(
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cfg_we,
	input  wire [BURST_W-1:0]       cfg_wdata,    // priority_burst
	input  wire                     s_tvalid,
	output logic                    s_tready,
	input  wire [PAYLOAD_WIDTH-1:0] s_tdata,      // payload
	input  wire [1:0]               s_tuser,      // operation, is_priority
	output logic                    m_tvalid,
	input  wire                     m_tready,
	// served_valid, served_priority, served_payload, head_valid, head_priority,
	// head_payload, dropped, priority_fill, normal_fill, zero fill
	output logic [OUT_W-1:0]        m_tdata
);

	logic [BURST_W-1:0] limit_q;
	logic [BURST_W-1:0] burst_q;
	logic               pend_q;
	logic               m_valid_q;
	logic [OUT_W-1:0]   m_data_q;

	// served part of the result, latched at acceptance
	logic                     srv_valid_q;
	logic                     srv_prio_q;
	logic [PAYLOAD_WIDTH-1:0] srv_pay_q;
	logic                     drop_q;

	q_ctrl_t p_ctrl, n_ctrl;
	q_stat_t p_stat, n_stat;

	logic in_acc;
	logic op, cls;
	src_t src, head_src;

	logic                     head_valid, head_prio;
	logic [PAYLOAD_WIDTH-1:0] head_pay;

	assign op  = s_tuser[0];
	assign cls = s_tuser[1];

	// one word in flight; output register must be free by the time it loads
	assign s_tready = !pend_q && (!m_valid_q || m_tready);
	assign in_acc   = s_tvalid && s_tready;

	assign src = choose_src(p_stat.count, n_stat.count, burst_q, limit_q);

	always_comb begin
		p_ctrl.enq = in_acc && (op == OP_ENQUEUE) &&  cls && !p_stat.full;
		n_ctrl.enq = in_acc && (op == OP_ENQUEUE) && !cls && !n_stat.full;
		p_ctrl.deq = in_acc && (op == OP_DEQUEUE)
		             && (src == SRC_PRIO_CNT || src == SRC_PRIO_HOLD);
		n_ctrl.deq = in_acc && (op == OP_DEQUEUE) && (src == SRC_NORM);
	end

	twq_queue u_prio (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (p_ctrl),
		.wr_data (s_tdata),
		.stat    (p_stat)
	);

	twq_queue u_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (n_ctrl),
		.wr_data (s_tdata),
		.stat    (n_stat)
	);

	// config register and burst counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= BURST_RESET;
			burst_q <= '0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (n_ctrl.deq) begin
				burst_q <= '0;
			end else if (p_ctrl.deq && src == SRC_PRIO_CNT && burst_q != BURST_MAX) begin
				burst_q <= burst_q + BURST_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else begin
			pend_q <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			srv_valid_q <= p_ctrl.deq || n_ctrl.deq;
			srv_prio_q  <= p_ctrl.deq;
			srv_pay_q   <= p_ctrl.deq ? p_stat.head
			             : (n_ctrl.deq ? n_stat.head : '0);
			drop_q      <= (op == OP_ENQUEUE) && (cls ? p_stat.full : n_stat.full);
		end
	end

	// head view from the state after the update
	assign head_src = choose_src(p_stat.count, n_stat.count, burst_q, limit_q);

	always_comb begin
		head_valid = 1'b0;
		head_prio  = 1'b0;
		head_pay   = '0;
		unique case (head_src)
			SRC_PRIO_CNT, SRC_PRIO_HOLD: begin
				head_valid = 1'b1;
				head_prio  = 1'b1;
				head_pay   = p_stat.head;
			end
			SRC_NORM: begin
				head_valid = 1'b1;
				head_pay   = n_stat.head;
			end
			default: begin
				head_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (pend_q) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q) begin
			m_data_q <= OUT_W'({n_stat.count, p_stat.count, drop_q,
			                    head_pay, head_prio, head_valid,
			                    srv_pay_q, srv_prio_q, srv_valid_q});
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

`ifndef SYNTHESIS
	// a queue never holds more than its depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		p_stat.count <= CNT_W'(QUEUE_DEPTH) && n_stat.count <= CNT_W'(QUEUE_DEPTH))
		else $error("queue fill beyond depth");

	// an accepted word blocks the input while pending, then its result is presented
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (!s_tready ##1 m_tvalid))
		else $error("accepted word gave no result");

	// only one queue moves per word
	a_one_queue: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({p_ctrl.enq, p_ctrl.deq, n_ctrl.enq, n_ctrl.deq}) <= 1)
		else $error("both queues updated by one word");

	// a served entry and a drop never share a result
	a_serve_drop: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !(srv_valid_q && drop_q))
		else $error("served and dropped together");
`endif

endmodule

`default_nettype wire

// ===== hdl/twq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module twq_cell
	import twq_pkg::*;
(
	input  wire                      clk,
	input  wire                      wr,
	input  wire                      shift,
	input  wire [PAYLOAD_WIDTH-1:0]  wr_data,
	input  wire [PAYLOAD_WIDTH-1:0]  nbr_data,
	output logic [PAYLOAD_WIDTH-1:0] data
);

	logic [PAYLOAD_WIDTH-1:0] data_q;

	// payload only, no reset: a cell is read only once written
	always_ff @(posedge clk) begin
		if (wr) begin
			data_q <= wr_data;
		end else if (shift) begin
			data_q <= nbr_data;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

// ===== hdl/twq_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module twq_queue
	import twq_pkg::*;
(
	input  wire                     clk,
	input  wire                     arst_n,
	input  q_ctrl_t                 ctrl,
	input  wire [PAYLOAD_WIDTH-1:0] wr_data,
	output q_stat_t                 stat
);

	logic [CNT_W-1:0]         count_q;
	logic [PAYLOAD_WIDTH-1:0] cell_data [QUEUE_DEPTH];

	// head sits in cell 0; a dequeue moves every cell one place towards it
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                     wr_i;
		logic [PAYLOAD_WIDTH-1:0] nbr_i;

		assign wr_i = ctrl.enq && (count_q == CNT_W'(i));

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign nbr_i = '0;
		end else begin : g_mid
			assign nbr_i = cell_data[i+1];
		end

		twq_cell u_cell (
			.clk      (clk),
			.wr       (wr_i),
			.shift    (ctrl.deq),
			.wr_data  (wr_data),
			.nbr_data (nbr_i),
			.data     (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.enq) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctrl.deq) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	assign stat.count = count_q;
	assign stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.head  = cell_data[0];

endmodule

`default_nettype wire
